@@ rtl/kcc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package kcc_pkg;

  localparam int KEYS = 4;
  localparam int CNT_W = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_CUTOFF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WINDOW = 2'd2;

  localparam logic [CNT_W-1:0] LONG_PRESS_RST = 8'd70;
  localparam logic [CNT_W-1:0] RELEASE_CUTOFF_RST = 8'd200;
  localparam logic [CNT_W-1:0] DOUBLE_WINDOW_RST = 8'd35;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_HELD = 2'd2
  } phase_t;

  typedef struct packed {
    logic [CNT_W-1:0] long_press_ticks;
    logic [CNT_W-1:0] release_cutoff_ticks;
    logic [CNT_W-1:0] double_click_window;
  } cfg_t;

  typedef struct packed {
    logic sgl;
    logic dbl;
    logic lng;
  } ev_t;

endpackage

`default_nettype wire

@@ rtl/kcc_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kcc_lane (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire logic          released,
  input  wire kcc_pkg::cfg_t cfg,
  output kcc_pkg::ev_t       ev
);

  kcc_pkg::phase_t phase;
  kcc_pkg::phase_t phase_next;
  logic [kcc_pkg::CNT_W-1:0] hold;
  logic [kcc_pkg::CNT_W-1:0] hold_next;
  logic [kcc_pkg::CNT_W-1:0] wcount;
  logic [kcc_pkg::CNT_W-1:0] wcount_next;
  logic wopen;
  logic wopen_next;
  logic [kcc_pkg::CNT_W-1:0] wcount_mid;
  logic wopen_mid;
  logic short_rel;
  logic late_rel;

  assign short_rel = released && (hold < cfg.long_press_ticks);
  assign late_rel = released && (hold >= cfg.release_cutoff_ticks);

  always_comb begin
    phase_next = phase;
    unique case (phase)
      kcc_pkg::PH_DEBOUNCE: begin
        phase_next = released ? kcc_pkg::PH_IDLE : kcc_pkg::PH_HELD;
      end
      kcc_pkg::PH_HELD: begin
        if (short_rel || late_rel) begin
          phase_next = kcc_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_next = released ? kcc_pkg::PH_IDLE : kcc_pkg::PH_DEBOUNCE;
      end
    endcase
  end

  always_comb begin
    hold_next = hold;
    wopen_mid = wopen;
    wcount_mid = wcount;
    ev = '0;
    unique case (phase)
      kcc_pkg::PH_DEBOUNCE: begin
      end
      kcc_pkg::PH_HELD: begin
        if (short_rel) begin
          if (!wopen) begin
            wopen_mid = 1'b1;
            wcount_mid = '0;
          end else begin
            ev.dbl = 1'b1;
            wopen_mid = 1'b0;
          end
        end else if (!late_rel) begin
          ev.lng = (hold >= cfg.long_press_ticks);
          if (hold != kcc_pkg::CNT_MAX) begin
            hold_next = hold + 1'b1;
          end
        end
      end
      default: begin
        if (!released) begin
          hold_next = '0;
        end
      end
    endcase

    // The window is counted after the phase logic, so a window opened on
    // this tick already counts once.
    wopen_next = wopen_mid;
    wcount_next = wcount_mid;
    if (wopen_mid) begin
      if (wcount_mid != kcc_pkg::CNT_MAX) begin
        wcount_next = wcount_mid + 1'b1;
      end
      if (wcount_next >= cfg.double_click_window) begin
        ev.sgl = 1'b1;
        wopen_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= kcc_pkg::PH_IDLE;
      hold <= '0;
      wcount <= '0;
      wopen <= 1'b0;
    end else if (step) begin
      phase <= phase_next;
      hold <= hold_next;
      wcount <= wcount_next;
      wopen <= wopen_next;
    end
  end

  a_long_only_held: assert property (@(posedge clk) disable iff (rst)
    ev.lng |-> phase == kcc_pkg::PH_HELD)
    else $error("long event outside held phase");

  a_single_double_excl: assert property (@(posedge clk) disable iff (rst)
    !(ev.sgl && ev.dbl))
    else $error("single and double click in the same tick");

  a_press_debounce: assert property (@(posedge clk) disable iff (rst)
    (step && phase == kcc_pkg::PH_IDLE && !released) |=> phase == kcc_pkg::PH_DEBOUNCE)
    else $error("press from idle did not enter debounce");

  a_hold_no_step: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(hold) && $stable(wopen) && $stable(wcount))
    else $error("lane state changed without a tick");

endmodule

`default_nettype wire

@@ rtl/kcc_merge.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kcc_merge (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      step,
  input  wire kcc_pkg::ev_t              lane_ev [kcc_pkg::KEYS],
  input  wire logic                      out_ready,
  output logic                           take,
  output logic                           out_valid,
  output logic [kcc_pkg::KEYS-1:0]       single_events,
  output logic [kcc_pkg::KEYS-1:0]       double_events,
  output logic [kcc_pkg::KEYS-1:0]       long_events
);

  logic [kcc_pkg::KEYS-1:0] sgl_bits;
  logic [kcc_pkg::KEYS-1:0] dbl_bits;
  logic [kcc_pkg::KEYS-1:0] lng_bits;

  always_comb begin
    for (int k = 0; k < kcc_pkg::KEYS; k++) begin
      sgl_bits[k] = lane_ev[k].sgl;
      dbl_bits[k] = lane_ev[k].dbl;
      lng_bits[k] = lane_ev[k].lng;
    end
  end

  // A new word may enter whenever the output register is empty or draining.
  assign take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      single_events <= sgl_bits;
      double_events <= dbl_bits;
      long_events <= lng_bits;
    end
  end

endmodule

`default_nettype wire

@@ rtl/key_click_classifier.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Classifies presses of four active-low keys into single clicks, double clicks
// and long presses, one scan tick per input word. Each key has its own lane
// with a two-sample debouncer, a hold counter and a double-click window
// counter; the lanes run side by side and their event bits are gathered into
// one registered output word. A tick is accepted every clock cycle while the
// output register is empty or being read, and its result appears in the next
// cycle from the single output register. The user must write the three
// thresholds through cfg_we, cfg_index and cfg_data only while the block is
// idle; the block does not enforce this. Writes to unused indexes are ignored.

module key_click_classifier (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [kcc_pkg::KEYS-1:0]          key_levels,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [kcc_pkg::KEYS-1:0]               single_events,
  output logic [kcc_pkg::KEYS-1:0]               double_events,
  output logic [kcc_pkg::KEYS-1:0]               long_events,
  input  wire logic                              cfg_we,
  input  wire logic [kcc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [kcc_pkg::CNT_W-1:0]         cfg_data
);

  kcc_pkg::cfg_t cfg;
  kcc_pkg::ev_t lane_ev [kcc_pkg::KEYS];
  logic step;

  assign step = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_ticks <= kcc_pkg::LONG_PRESS_RST;
      cfg.release_cutoff_ticks <= kcc_pkg::RELEASE_CUTOFF_RST;
      cfg.double_click_window <= kcc_pkg::DOUBLE_WINDOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kcc_pkg::REG_LONG_PRESS: cfg.long_press_ticks <= cfg_data;
        kcc_pkg::REG_RELEASE_CUTOFF: cfg.release_cutoff_ticks <= cfg_data;
        kcc_pkg::REG_DOUBLE_WINDOW: cfg.double_click_window <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  for (genvar k = 0; k < kcc_pkg::KEYS; k++) begin : g_lane
    kcc_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .step     (step),
      .released (key_levels[k]),
      .cfg      (cfg),
      .ev       (lane_ev[k])
    );
  end

  kcc_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .lane_ev       (lane_ev),
    .out_ready     (out_ready),
    .take          (in_ready),
    .out_valid     (out_valid),
    .single_events (single_events),
    .double_events (double_events),
    .long_events   (long_events)
  );

endmodule

`default_nettype wire
